FILE: hdl/clce_pkg.sv
// Shared types and codes for the circular list cursor engine.
package clce_pkg;

	// Opcodes carried by an input transaction
	localparam logic [2:0] OP_MOVE_NEXT  = 3'd0;
	localparam logic [2:0] OP_MOVE_PREV  = 3'd1;
	localparam logic [2:0] OP_INS_AFTER  = 3'd2;
	localparam logic [2:0] OP_INS_BEFORE = 3'd3;
	localparam logic [2:0] OP_POP        = 3'd4;
	localparam logic [2:0] OP_READ       = 3'd5;

	// Result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] value_in;
	} in_item_t;

	typedef struct packed {
		logic [31:0] value_out;
		logic [1:0]  status;
		logic [6:0]  node_count;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LINK,
		S_RESP
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic link;
		logic load_out;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_link;
	} dp_stat_t;

endpackage

FILE: hdl/clce_ctrl.sv
// Sequencing state machine and output valid for the list engine.
module clce_ctrl
	import clce_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.need_link ? S_LINK : S_RESP;
			end
			S_LINK: begin
				cmd.link = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output valid: set on load, cleared when the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == S_EXEC)
		else $error("accepted transaction not executed next cycle");
	a_link_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LINK |-> $past(state_q) == S_EXEC)
		else $error("link phase without execute phase");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");
`endif

endmodule

FILE: hdl/clce_dp.sv
// Datapath: link and value memories, list registers and result registers.
module clce_dp
	import clce_pkg::*;
#(
	parameter int POOL_NODES  = 64,
	parameter int VALUE_WIDTH = 32
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_cmd_t cmd,
	output dp_stat_t  stat,
	input  in_item_t  in_data,
	output out_item_t out_data
);

	localparam int AW = $clog2(POOL_NODES);
	localparam int CW = $clog2(POOL_NODES + 1);
	localparam int VW = VALUE_WIDTH;

	// Node pool memories
	logic [AW-1:0] next_mem [POOL_NODES];
	logic [AW-1:0] prev_mem [POOL_NODES];
	logic [VW-1:0] val_mem  [POOL_NODES];

	// List state
	logic [AW-1:0] cursor_q, free_head_q;
	logic [CW-1:0] size_q, fresh_q, free_size_q;

	// Latched transaction and registered memory reads
	in_item_t      item_q;
	logic [AW-1:0] rd_next_cur_q, rd_next_free_q, rd_prev_cur_q;
	logic [VW-1:0] rd_val_q;

	// Second link phase
	logic          l_next_en_q, l_prev_en_q;
	logic [AW-1:0] l_next_addr_q, l_next_data_q, l_prev_addr_q, l_prev_data_q;

	out_item_t res_q, out_q;

	// Execute-phase decisions
	logic [AW-1:0] cursor_d, free_head_d;
	logic [CW-1:0] size_d, fresh_d, free_size_d;
	logic          xn_en, xp_en, xv_en;
	logic [AW-1:0] xn_addr, xn_data, xp_addr, xp_data, xv_addr;
	logic          ln_en, lp_en;
	logic [AW-1:0] ln_addr, ln_data, lp_addr, lp_data;
	logic [VW-1:0] vout;
	logic [1:0]    stat_code;
	logic [63:0]   in_ext, vout_ext;
	logic [15:0]   size_ext;

	// Memory write ports
	logic          next_we, prev_we;
	logic [AW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;

	assign in_ext = 64'(item_q.value_in);

	// Operation decode over the registered reads
	always_comb begin
		logic          empty, have_free, have_fresh;
		logic [AW-1:0] n;
		empty       = (size_q == '0);
		have_free   = (free_size_q != '0);
		have_fresh  = (fresh_q != CW'(POOL_NODES));
		n           = have_free ? free_head_q : fresh_q[AW-1:0];
		cursor_d    = cursor_q;
		free_head_d = free_head_q;
		size_d      = size_q;
		fresh_d     = fresh_q;
		free_size_d = free_size_q;
		xn_en = 1'b0; xn_addr = n; xn_data = n;
		xp_en = 1'b0; xp_addr = n; xp_data = n;
		xv_en = 1'b0; xv_addr = n;
		ln_en = 1'b0; ln_addr = cursor_q; ln_data = n;
		lp_en = 1'b0; lp_addr = cursor_q; lp_data = n;
		vout      = '0;
		stat_code = STAT_OK;
		case (item_q.opcode)
			OP_MOVE_NEXT, OP_MOVE_PREV: begin
				if (empty) begin
					stat_code = STAT_EMPTY;
				end else begin
					cursor_d = (item_q.opcode == OP_MOVE_NEXT) ? rd_next_cur_q : rd_prev_cur_q;
				end
			end
			OP_INS_AFTER, OP_INS_BEFORE: begin
				if (!have_free && !have_fresh) begin
					stat_code = STAT_FULL;
				end else begin
					// take a node: recycled first, then a fresh one
					if (have_free) begin
						free_head_d = rd_next_free_q;
						free_size_d = free_size_q - CW'(1);
					end else begin
						fresh_d = fresh_q + CW'(1);
					end
					xv_en  = 1'b1;
					xn_en  = 1'b1;
					xp_en  = 1'b1;
					size_d = size_q + CW'(1);
					if (empty) begin
						cursor_d = n;
					end else if (item_q.opcode == OP_INS_AFTER) begin
						xn_data = rd_next_cur_q;
						xp_data = cursor_q;
						ln_en   = 1'b1;
						ln_addr = cursor_q;
						lp_en   = 1'b1;
						lp_addr = rd_next_cur_q;
					end else begin
						xp_data = rd_prev_cur_q;
						xn_data = cursor_q;
						ln_en   = 1'b1;
						ln_addr = rd_prev_cur_q;
						lp_en   = 1'b1;
						lp_addr = cursor_q;
					end
				end
			end
			OP_POP: begin
				if (empty) begin
					stat_code = STAT_EMPTY;
				end else begin
					vout = rd_val_q;
					// release the cursor node onto the free list
					xn_en       = 1'b1;
					xn_addr     = cursor_q;
					xn_data     = free_head_q;
					free_head_d = cursor_q;
					free_size_d = free_size_q + CW'(1);
					size_d      = size_q - CW'(1);
					if (rd_next_cur_q == cursor_q) begin
						cursor_d = '0;
					end else begin
						// unlink: prev of successor now, next of predecessor later
						xp_en    = 1'b1;
						xp_addr  = rd_next_cur_q;
						xp_data  = rd_prev_cur_q;
						ln_en    = 1'b1;
						ln_addr  = rd_prev_cur_q;
						ln_data  = rd_next_cur_q;
						cursor_d = rd_next_cur_q;
					end
				end
			end
			OP_READ: begin
				if (empty) begin
					stat_code = STAT_EMPTY;
				end else begin
					vout = rd_val_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.need_link = ln_en || lp_en;

	// Write port selection between execute and link phases
	always_comb begin
		if (cmd.exec) begin
			next_we    = xn_en;
			next_waddr = xn_addr;
			next_wdata = xn_data;
			prev_we    = xp_en;
			prev_waddr = xp_addr;
			prev_wdata = xp_data;
		end else begin
			next_we    = cmd.link && l_next_en_q;
			next_waddr = l_next_addr_q;
			next_wdata = l_next_data_q;
			prev_we    = cmd.link && l_prev_en_q;
			prev_waddr = l_prev_addr_q;
			prev_wdata = l_prev_data_q;
		end
	end

	// Link memories, two read ports on next
	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
		rd_next_cur_q  <= next_mem[cursor_q];
		rd_next_free_q <= next_mem[free_head_q];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_waddr] <= prev_wdata;
		end
		rd_prev_cur_q <= prev_mem[cursor_q];
	end

	// Value memory
	always_ff @(posedge clk) begin
		if (cmd.exec && xv_en) begin
			val_mem[xv_addr] <= in_ext[VW-1:0];
		end
		rd_val_q <= val_mem[cursor_q];
	end

	// List state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			free_head_q <= '0;
			size_q      <= '0;
			fresh_q     <= '0;
			free_size_q <= '0;
			l_next_en_q <= 1'b0;
			l_prev_en_q <= 1'b0;
		end else if (cmd.exec) begin
			cursor_q    <= cursor_d;
			free_head_q <= free_head_d;
			size_q      <= size_d;
			fresh_q     <= fresh_d;
			free_size_q <= free_size_d;
			l_next_en_q <= ln_en;
			l_prev_en_q <= lp_en;
		end
	end

	assign vout_ext = 64'(vout);
	assign size_ext = 16'(size_d);

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= in_data;
		end
		if (cmd.exec) begin
			l_next_addr_q       <= ln_addr;
			l_next_data_q       <= ln_data;
			l_prev_addr_q       <= lp_addr;
			l_prev_data_q       <= lp_data;
			res_q.value_out     <= vout_ext[31:0];
			res_q.status        <= stat_code;
			res_q.node_count    <= size_ext[6:0];
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	assign out_data = out_q;

`ifndef SYNTH
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= CW'(POOL_NODES))
		else $error("list size beyond pool");
	a_node_conservation: assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'(size_q) + (CW+1)'(free_size_q) == (CW+1)'(fresh_q))
		else $error("nodes lost or duplicated between list and free list");
	a_link_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link |-> (l_next_en_q || l_prev_en_q))
		else $error("link phase with no pending write");
`endif

endmodule

FILE: hdl/circular_list_cursor_engine.sv
// Top level of the circular list cursor engine.
// A circular doubly linked list held in a pool of POOL_NODES nodes, with a cursor on the
// current node. Each input transaction gives one result transaction. Moves, reads,
// inserts into an empty list, pops of the last node and rejected operations pass
// through the idle, execute and response states. Inserts into a non-empty list and
// pops with neighbours also pass through the link state between execute and response,
// because each link memory has a single write port and two link entries change. Memory
// reads are registered, which is why the decode has its own execute state. The next
// transaction is accepted only in the idle state, once the previous result has been
// loaded into the output register, where that result may still wait meanwhile; the
// next result then waits in the response state until the output register is taken.
// Node links and values are not cleared at reset; the list starts empty.
module circular_list_cursor_engine
	import clce_pkg::*;
#(
	parameter int POOL_NODES  = 64,
	parameter int VALUE_WIDTH = 32
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// Sequencer
	clce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Pool memories and list registers
	clce_dp #(
		.POOL_NODES  (POOL_NODES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule
